/* rtl/rqkr_pkg.sv */
package rqkr_pkg;

  // Default sizes
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 16;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_PEEK   = 3'd4,
    OP_ROTATE = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  // Update command broadcast to every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
    logic remove;
    logic rotate;
  } cell_ctrl_t;

endpackage

/* rtl/rqkr_cell.sv */
module rqkr_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned CNT_W   = 5,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                clk_i,
  input  rqkr_pkg::cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [ID_BITS-1:0]  key_i,
  input  logic [ID_BITS-1:0]  head_i,
  input  logic [ID_BITS-1:0]  next_i,
  input  logic                hit_i,
  output logic [ID_BITS-1:0]  entry_o,
  output logic                hit_o
);
  import rqkr_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

  logic [ID_BITS-1:0] entry_q, entry_d;
  logic               valid, next_valid, is_last, is_tail, match;

  // Position of this cell relative to the fill level
  assign valid      = IDX_C < count_i;
  assign next_valid = NEXT_C < count_i;
  assign is_last    = NEXT_C == count_i;
  assign is_tail    = IDX_C == count_i;

  // Key compare; the hit flag ripples towards the tail
  assign match = valid && (entry_q == key_i);
  assign hit_o = hit_i | match;

  // Entry update: load at the tail, take the neighbour's entry to close a gap, or rotate the head to the back
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push && is_tail) begin
      entry_d = key_i;
    end else if (ctrl_i.pop && next_valid) begin
      entry_d = next_i;
    end else if (ctrl_i.remove && hit_o && next_valid) begin
      entry_d = next_i;
    end else if (ctrl_i.rotate) begin
      if (is_last) begin
        entry_d = head_i;
      end else if (valid) begin
        entry_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/ready_queue_with_keyed_removal_core.sv */
// Ordered ready queue of process identifiers held in a row of cells, head at
// cell 0. An operation is transferred when start is high and busy is low; busy
// then stays high for one cycle while every cell compares its entry with the
// key and the row shifts to close a gap. A new operation may be started in
// the cycle its result is shown. Each operation gives exactly one result,
// shown on the result ports for a single cycle with done_o high; the receiver
// cannot stall it, so it must take the result in that cycle. Remove and find
// act on the match nearest the head.
module ready_queue_with_keyed_removal_core #(
  parameter int unsigned QUEUE_DEPTH = rqkr_pkg::QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = rqkr_pkg::ID_BITS,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rqkr_pkg::OP_W-1:0]     op_i,
  input  logic [ID_BITS-1:0]            pid_i,
  output logic                          done_o,
  output logic [rqkr_pkg::STATUS_W-1:0] status_o,
  output logic [ID_BITS-1:0]            result_pid_o,
  output logic [CNT_W-1:0]              occupancy_o
);
  import rqkr_pkg::*;

  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] TWO_C  = CNT_W'(2);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                  state_q, state_d;
  logic [OP_W-1:0]         op_q;
  logic [ID_BITS-1:0]      pid_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    done_q, done_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [ID_BITS-1:0]      result_q, result_d;
  cell_ctrl_t              ctrl;
  logic [ID_BITS-1:0]      entries [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH:0]    hits;
  logic                    empty, found;

  // Cell row
  assign entries[QUEUE_DEPTH] = '0;
  assign hits[0]              = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    rqkr_cell #(
      .IDX    (g),
      .CNT_W  (CNT_W),
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .key_i  (pid_q),
      .head_i (entries[0]),
      .next_i (entries[g+1]),
      .hit_i  (hits[g]),
      .entry_o(entries[g]),
      .hit_o  (hits[g+1])
    );
  end

  assign empty = count_q == '0;
  assign found = hits[QUEUE_DEPTH];

  // Operation decode and status
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_OK;
    result_d = '0;
    state_d  = state_q;
    done_d   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (op_q)
          OP_PUSH: begin
            if (count_q == FULL_C) begin
              status_d = ST_FULL;
            end else begin
              ctrl.push = 1'b1;
              count_d   = count_q + ONE_C;
            end
          end
          OP_POP, OP_PEEK: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              result_d = entries[0];
              if (op_q == OP_POP) begin
                ctrl.pop = 1'b1;
                count_d  = count_q - ONE_C;
              end
            end
          end
          OP_REMOVE, OP_FIND: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else if (!found) begin
              status_d = ST_NOT_FOUND;
            end else begin
              // a match holds exactly the key
              result_d = pid_q;
              if (op_q == OP_REMOVE) begin
                ctrl.remove = 1'b1;
                count_d     = count_q - ONE_C;
              end
            end
          end
          OP_ROTATE: begin
            if (count_q < TWO_C) begin
              status_d = ST_SHORT;
            end else begin
              ctrl.rotate = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      result_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (done_d) begin
        status_q <= status_d;
        result_q <= result_d;
      end
    end
  end

  // Operand capture on transfer
  always_ff @(posedge clk_i) begin
    if (start && state_q == S_IDLE) begin
      op_q  <= op_i;
      pid_q <= pid_i;
    end
  end

  assign busy         = state_q == S_EXEC;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign result_pid_o = result_q;
  assign occupancy_o  = count_q;

endmodule

/* sim/rqkr_checker.sv */
`timescale 1ns / 100ps

// Watches the command and result channels of the ready queue, keeps its own
// copy of the queue and matches every result against the oldest prediction.
module rqkr_checker #(
  parameter int unsigned DEPTH  = rqkr_pkg::QUEUE_DEPTH,
  parameter int unsigned ID_W   = rqkr_pkg::ID_BITS,
  localparam int unsigned OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [rqkr_pkg::OP_W-1:0]     op_i,
  input  logic [ID_W-1:0]               pid_i,
  input  logic                          done_i,
  input  logic [rqkr_pkg::STATUS_W-1:0] status_i,
  input  logic [ID_W-1:0]               result_pid_i,
  input  logic [OCC_W-1:0]              occupancy_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import rqkr_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  pid;
    logic [OCC_W-1:0] occ;
  } queue_result_t;

  logic [ID_W-1:0] ready_q[$];      // head at index 0
  queue_result_t   outcome_q[$];    // predicted results, oldest first
  queue_result_t   oldest;
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    // keep the log short if the block is badly broken
    if (mismatches < 100)
      $display("checker: %0t %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Carry out one operation on the shadow queue and give its result
  function automatic queue_result_t apply_op(logic [OP_W-1:0] code, logic [ID_W-1:0] id);
    queue_result_t r;
    int            pos;
    r.status = ST_OK;
    r.pid    = '0;
    pos      = -1;
    case (code)
      OP_PUSH: begin
        if (ready_q.size() >= DEPTH) r.status = ST_FULL;
        else ready_q.push_back(id);
      end
      OP_POP, OP_PEEK: begin
        if (ready_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pid = ready_q[0];
          if (code == OP_POP) void'(ready_q.pop_front());
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (ready_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // match nearest the head wins
          for (int i = 0; i < ready_q.size(); i++)
            if (pos < 0 && ready_q[i] == id) pos = i;
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.pid = ready_q[pos];
            if (code == OP_REMOVE) ready_q.delete(pos);
          end
        end
      end
      OP_ROTATE: begin
        if (ready_q.size() < 2) r.status = ST_SHORT;
        else ready_q.push_back(ready_q.pop_front());
      end
      default: ;  // spare codes leave the queue alone
    endcase
    r.occ = OCC_W'(ready_q.size());
    return r;
  endfunction

  // Compare the result shown this cycle, then record any new transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ready_q.delete();
      outcome_q.delete();
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no operation outstanding", status_i, 0);
        end else begin
          oldest = outcome_q.pop_front();
          if (status_i !== oldest.status)
            report_mismatch("status", status_i, oldest.status);
          if (result_pid_i !== oldest.pid)
            report_mismatch("result pid", result_pid_i, oldest.pid);
          if (occupancy_i !== oldest.occ)
            report_mismatch("occupancy", occupancy_i, oldest.occ);
        end
      end
      if (start_i && !busy_i) outcome_q.push_back(apply_op(op_i, pid_i));
    end
    pending_o <= outcome_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import rqkr_pkg::*;

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  // Spare operation codes, expected to be ignored
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned PHASE_ITEMS = 575;
  localparam int unsigned SEGMENT     = 40;
  localparam int unsigned MAX_GAP     = 40;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [OP_W-1:0]     op    = '0;
  logic [ID_BITS-1:0]  pid   = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [ID_BITS-1:0]  result_pid;
  logic [OCC_W-1:0]    occupancy;
  int                  fail_count;
  int                  pending;

  int unsigned         idle_pct;
  int unsigned         fill_bias;
  logic [ID_BITS-1:0]  pool_base;

  ready_queue_with_keyed_removal_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .op_i         (op),
    .pid_i        (pid),
    .done_o       (done),
    .status_o     (status),
    .result_pid_o (result_pid),
    .occupancy_o  (occupancy)
  );

  rqkr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .op_i         (op),
    .pid_i        (pid),
    .done_i       (done),
    .status_i     (status),
    .result_pid_i (result_pid),
    .occupancy_i  (occupancy),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hold start until the block takes the command, then idle at random
  task automatic send_op(logic [OP_W-1:0] code, logic [ID_BITS-1:0] id);
    int unsigned gap;
    start <= 1'b1;
    op    <= code;
    pid   <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random command; the segment bias swings the queue between empty and full
  task automatic send_random();
    int unsigned        r;
    logic [OP_W-1:0]    code;
    logic [ID_BITS-1:0] id;
    r = $urandom_range(99);
    if (r < fill_bias) begin
      code = OP_PUSH;
    end else begin
      r = $urandom_range(99);
      if (r < 2)       code = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      else if (r < 32) code = OP_REMOVE;
      else if (r < 57) code = OP_FIND;
      else if (r < 77) code = OP_POP;
      else if (r < 87) code = OP_PEEK;
      else             code = OP_ROTATE;
    end
    // mostly a small pool of ids so that lookups hit and duplicates build up
    if ($urandom_range(99) < 60) id = pool_base ^ ID_BITS'($urandom_range(7));
    else id = ID_BITS'($urandom_range(16'hFFFF));
    send_op(code, id);
  endtask

  initial begin
    idle_pct  = 36;
    fill_bias = 50;
    pool_base = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: every lookup reports empty, rotate is too short
    send_op(OP_POP, 16'h0000);
    send_op(OP_PEEK, 16'h0000);
    send_op(OP_REMOVE, 16'hFFFF);
    send_op(OP_FIND, 16'h0000);
    send_op(OP_ROTATE, 16'h0000);
    // single entry, rotate still too short
    send_op(OP_PUSH, 16'h0000);
    send_op(OP_ROTATE, 16'hFFFF);
    // duplicates, miss, rotate, removal nearest the head
    send_op(OP_PUSH, 16'hFFFF);
    send_op(OP_PUSH, 16'h0000);
    send_op(OP_FIND, 16'h1234);
    send_op(OP_ROTATE, 16'h0000);
    send_op(OP_FIND, 16'h0000);
    send_op(OP_REMOVE, 16'h0000);
    send_op(OP_SPARE_LO, 16'h0000);
    send_op(OP_SPARE_HI, 16'hFFFF);
    // fill up, then one refused push
    for (int i = 0; i < QUEUE_DEPTH - 2; i++)
      send_op(OP_PUSH, ID_BITS'((i % 2) ? (16'hAA00 | i) : (16'h5500 | i)));
    send_op(OP_PUSH, 16'hFFFF);
    send_op(OP_POP, 16'h0000);
    drain();

    // Random traffic: sender busy, sender mostly idle, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 84 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % SEGMENT == 0) begin
          case ($urandom_range(3))
            0:       fill_bias = 15;
            1:       fill_bias = 35;
            2:       fill_bias = 50;
            default: fill_bias = 75;
          endcase
          pool_base = ID_BITS'($urandom_range(16'hFFFF));
        end
        send_random();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
